// ===== rtl/core/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// Types, field widths and codes shared by the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int KIND_W    = 2;
  localparam int ID_W      = 10;
  localparam int GEN_W     = 32;
  localparam int OWNER_W   = 7;
  localparam int PROTO_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam int SLOTS_DEFAULT = 1024;
  localparam int COUNT_RESET   = 1024;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OWNER = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_STALE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    slot_id;
    logic [GEN_W-1:0]   generation;
    logic [OWNER_W-1:0] owner;
    logic [PROTO_W-1:0] protocol;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;
    logic [GEN_W-1:0]    result_generation;
    logic [OWNER_W-1:0]  result_owner;
    logic [COUNT_W-1:0]  free_slots;
  } rsp_t;

  // one slot entry as kept in the slot memory
  typedef struct packed {
    logic [GEN_W-1:0]   generation;
    logic               occupied;
    logic [PROTO_W-1:0] protocol;
  } slot_word_t;

  // write-back decided for the current item
  typedef struct packed {
    logic       slot_we;
    slot_word_t word;
    logic       push;
  } ght_upd_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_STACK,
    S_SLOT
  } ght_state_t;

endpackage

// ===== rtl/core/ght_eval.sv =====
// ----------------------------------------------------------------------------
// ght_eval
// Checks one item against the slot entry read from memory and works out the
// result and the write-back to the slot and free stack.
// ----------------------------------------------------------------------------
module ght_eval import ght_pkg::*; (
  input  cmd_t               item,
  input  logic [COUNT_W-1:0] cur_id,
  input  logic               stack_empty,
  input  slot_word_t         word,
  input  logic [OWNER_W-1:0] owner_id,
  input  logic [COUNT_W-1:0] slot_count,
  input  logic [COUNT_W-1:0] depth,
  output rsp_t               rsp,
  output ght_upd_t           upd
);

  logic [GEN_W-1:0] gen_alloc;
  logic [GEN_W-1:0] gen_inc;
  logic [GEN_W-1:0] gen_rel;
  logic             in_range;
  logic             handle_ok;

  assign gen_alloc = (word.generation == '0) ? GEN_W'(1) : word.generation;
  assign gen_inc   = word.generation + GEN_W'(1);
  // zero is skipped when the generation wraps
  assign gen_rel   = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign in_range  = cur_id < slot_count;
  assign handle_ok = in_range && word.occupied && (word.generation == item.generation) &&
                     ((item.kind == KIND_RELEASE) || (word.protocol == item.protocol));

  always_comb begin
    rsp        = '0;
    rsp.status = STAT_STALE;
    upd        = '0;
    upd.word   = word;
    case (item.kind)
      KIND_ALLOC: begin
        if (stack_empty || !in_range) begin
          rsp.status = STAT_FULL;
        end else begin
          rsp.status            = STAT_OK;
          rsp.result_id         = ID_W'(cur_id);
          rsp.result_generation = gen_alloc;
          rsp.result_owner      = owner_id;
          upd.slot_we           = 1'b1;
          upd.word.generation   = gen_alloc;
          upd.word.occupied     = 1'b1;
          upd.word.protocol     = item.protocol;
        end
      end
      KIND_RELEASE, KIND_LOOKUP: begin
        if (item.owner != owner_id) begin
          rsp.status = STAT_OWNER;
        end else if (handle_ok) begin
          rsp.status            = STAT_OK;
          rsp.result_id         = item.slot_id;
          rsp.result_generation = item.generation;
          rsp.result_owner      = owner_id;
          if (item.kind == KIND_RELEASE) begin
            upd.slot_we         = 1'b1;
            upd.word.generation = gen_rel;
            upd.word.occupied   = 1'b0;
            upd.push            = depth < slot_count;
          end
        end
      end
      default: begin
        rsp.status = STAT_STALE;
      end
    endcase
    rsp.free_slots = upd.push ? depth + COUNT_W'(1) : depth;
  end

endmodule

// ===== rtl/core/generational_handle_table.sv =====
// A lookup or release result is registered in the slot state that follows the
// taking of the item; an allocate that pops the free stack passes first through
// the stack state, reading the slot memory at the id that the free stack gave.
// One item is in work at a time: no new item is taken until its result is loaded,
// which can wait on rsp_ready. Reset and every slot_count write start a clearing
// pass over slot_count entries (1024 by default) during which cmd_ready stays low.
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map with per-slot generations, a LIFO free stack and owner checks.
// ----------------------------------------------------------------------------
module generational_handle_table import ght_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] CNT_MAX =
    COUNT_W'((SLOTS > COUNT_LIMIT) ? COUNT_LIMIT : SLOTS);
  localparam logic [COUNT_W-1:0] CNT_RESET =
    COUNT_W'((COUNT_RESET > SLOTS) ? SLOTS : COUNT_RESET);

  ght_state_t         state;
  ght_state_t         state_next;
  cmd_t               cmd_q;
  logic [COUNT_W-1:0] cur_id;
  logic               empty_q;
  logic [COUNT_W-1:0] depth;
  logic [COUNT_W-1:0] slot_count;
  logic [OWNER_W-1:0] owner_id;
  logic [COUNT_W-1:0] clr_idx;

  slot_word_t         slot_mem [SLOTS];
  slot_word_t         slot_rd;
  logic [COUNT_W-1:0] stk_mem [SLOTS];
  logic [COUNT_W-1:0] stk_rd;

  logic               slot_re;
  logic [IW-1:0]      slot_ra;
  logic               slot_we;
  logic [IW-1:0]      slot_wa;
  slot_word_t         slot_wd;
  logic               stk_re;
  logic [IW-1:0]      stk_ra;
  logic               stk_we;
  logic [IW-1:0]      stk_wa;
  logic [COUNT_W-1:0] stk_wd;
  logic               done;

  logic               cmd_take;
  logic               cfg_take;
  logic               count_write;
  logic               stack_empty;
  logic [COUNT_W-1:0] cnt_clamp;
  rsp_t               eval_rsp;
  ght_upd_t           upd;

  assign cfg_ready   = 1'b1;
  assign cmd_take    = cmd_valid && cmd_ready;
  assign cfg_take    = cfg_valid && cfg_ready;
  assign count_write = cfg_take && (cfg_index == CFG_SLOT_COUNT);
  assign stack_empty = (depth == '0) || (depth > slot_count);
  assign cnt_clamp   = (cfg_data == '0)    ? COUNT_W'(1) :
                       (cfg_data > CNT_MAX) ? CNT_MAX : cfg_data;

  ght_eval u_eval (
    .item        (cmd_q),
    .cur_id      (cur_id),
    .stack_empty (empty_q),
    .word        (slot_rd),
    .owner_id    (owner_id),
    .slot_count  (slot_count),
    .depth       (depth),
    .rsp         (eval_rsp),
    .upd         (upd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == slot_count - COUNT_W'(1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_take) begin
          if ((cmd.kind == KIND_ALLOC) && !stack_empty) state_next = S_STACK;
          else state_next = S_SLOT;
        end
      end
      S_STACK: state_next = S_SLOT;
      S_SLOT: begin
        if (done) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
    if (count_write) state_next = S_CLEAR;
  end

  // memory ports and handshake
  always_comb begin
    cmd_ready = 1'b0;
    done      = 1'b0;
    slot_re   = 1'b0;
    slot_ra   = IW'(cmd.slot_id);
    slot_we   = 1'b0;
    slot_wa   = IW'(cur_id);
    slot_wd   = upd.word;
    stk_re    = 1'b0;
    stk_ra    = IW'(depth - COUNT_W'(1));
    stk_we    = 1'b0;
    stk_wa    = IW'(depth);
    stk_wd    = cur_id;
    case (state)
      S_CLEAR: begin
        // refill the stack so that id zero ends up on top
        slot_we = 1'b1;
        slot_wa = IW'(clr_idx);
        slot_wd = '0;
        stk_we  = 1'b1;
        stk_wa  = IW'(clr_idx);
        stk_wd  = slot_count - COUNT_W'(1) - clr_idx;
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        slot_re   = cmd_valid;
        stk_re    = cmd_valid;
      end
      S_STACK: begin
        slot_re = 1'b1;
        slot_ra = IW'(stk_rd);
      end
      S_SLOT: begin
        done    = !rsp_valid || rsp_ready;
        slot_we = done && upd.slot_we;
        stk_we  = done && upd.push;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_rd <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      slot_count <= CNT_RESET;
      depth      <= CNT_RESET;
      owner_id   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (count_write) begin
        clr_idx <= '0;
      end else if (state == S_CLEAR) begin
        clr_idx <= clr_idx + COUNT_W'(1);
      end
      if (cmd_take) begin
        cmd_q   <= cmd;
        cur_id  <= COUNT_W'(cmd.slot_id);
        empty_q <= stack_empty;
      end else if (state == S_STACK) begin
        cur_id <= stk_rd;
      end
      if (count_write) begin
        depth <= cnt_clamp;
      end else if (cmd_take && (cmd.kind == KIND_ALLOC) && !stack_empty) begin
        depth <= depth - COUNT_W'(1);
      end else if (done && upd.push) begin
        depth <= depth + COUNT_W'(1);
      end
      if (done) begin
        rsp       <= eval_rsp;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_take && (cfg_index == CFG_OWNER_ID)) owner_id <= OWNER_W'(cfg_data);
      if (count_write) slot_count <= cnt_clamp;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= slot_count)
    else $error("free stack depth above slot count");

  a_rsp_from_slot: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_SLOT)
    else $error("result loaded outside slot stage");

  a_pop_is_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SLOT) && (cmd_q.kind == KIND_ALLOC) && !empty_q &&
    (cur_id < slot_count) |-> !slot_rd.occupied)
    else $error("allocated slot was already occupied");

endmodule
